### hw/rtl/cpd_pkg.sv
// Shared types and constants for the CRC-16 packet deframer.
// No dependencies; used by the channel interfaces, the deframer top and the testbench.
`timescale 1ns / 1ps

package cpd_pkg;

  localparam int DEFAULT_MAX_WORDS = 32;

  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;

  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd85;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_WORD    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_WAIT_START,
    PH_COUNT,
    PH_DATA,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_WAIT_END,
    PH_EMIT
  } phase_t;

endpackage

### hw/rtl/cpd_in_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on cpd_pkg.
`timescale 1ns / 1ps

interface cpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [cpd_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/cpd_out_if.sv
// Result output channel: valid/ready handshake carrying one frame result item.
// Depends on cpd_pkg.
`timescale 1ns / 1ps

interface cpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpd_pkg::STATUS_W-1:0]  frame_status;
  logic [cpd_pkg::INDEX_W-1:0]   word_index;
  logic [cpd_pkg::WORD_W-1:0]    word_value;
  logic                          last_of_frame;

  modport source (output valid, output frame_status, output word_index,
                  output word_value, output last_of_frame, input ready);
  modport sink   (input valid, input frame_status, input word_index,
                  input word_value, input last_of_frame, output ready);
endinterface

### hw/rtl/cpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/crc16_packet_deframer_top.sv
// CRC-16 packet deframer: byte parser, running CRC and payload store readout.
// Depends on cpd_pkg, cpd_in_if, cpd_out_if and cpd_ram.
//
// Bytes are taken one per cycle while a frame is parsed (START, COUNT, COUNT
// little-endian words, CRC low, CRC high, END); the CRC-16 (0xA001, init
// 0xFFFF) over START, COUNT and data is updated in the same cycle. Words are
// kept in a MAX_WORDS-deep RAM. An END byte that closes a good frame holds
// the byte input while its words stream out of the RAM's single read port,
// one per cycle unless the output stalls. An END byte is taken only once the
// output register is free or being emptied; a CRC error or empty frame gives
// one status item. No clearing pass after reset.
`timescale 1ns / 1ps

module crc16_packet_deframer_top #(
  parameter int MAX_WORDS = cpd_pkg::DEFAULT_MAX_WORDS
) (
  input  logic                              clk,
  input  logic                              rst,
  cpd_in_if.sink                            rx,
  cpd_out_if.source                         result,
  input  logic                              cfg_we,
  input  logic [cpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cpd_pkg::BYTE_W-1:0]        cfg_data
);

  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [cpd_pkg::BYTE_W-1:0] MAX_BYTE = cpd_pkg::BYTE_W'(MAX_WORDS);

  function automatic logic [cpd_pkg::WORD_W-1:0] crc_byte(
    input logic [cpd_pkg::WORD_W-1:0] crc_in,
    input logic [cpd_pkg::BYTE_W-1:0] b
  );
    logic [cpd_pkg::WORD_W-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ cpd_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  cpd_pkg::phase_t phase, phase_next;

  logic [cpd_pkg::BYTE_W-1:0] start_marker;
  logic [cpd_pkg::BYTE_W-1:0] end_marker;
  logic [CW-1:0]              word_count;
  logic [CW-1:0]              word_position;
  logic [CW-1:0]              pos_inc;
  logic                       high_byte_next;
  logic [cpd_pkg::WORD_W-1:0] running_crc;
  logic [cpd_pkg::WORD_W-1:0] received_crc;
  logic [cpd_pkg::BYTE_W-1:0] low_byte;

  logic [CW-1:0]              rd_ptr;
  logic [CW-1:0]              rd_ptr_inc;
  logic                       pend;
  logic [CW-1:0]              pend_idx;
  logic                       pend_last;

  logic                       out_valid;
  cpd_pkg::status_t           out_status;
  logic [cpd_pkg::INDEX_W-1:0] out_idx;
  logic [cpd_pkg::WORD_W-1:0] out_value;
  logic                       out_last;

  logic                       accept;
  logic                       is_start;
  logic                       is_end;
  logic                       crc_ok;
  logic                       count_ok;
  logic                       all_issued;
  logic                       move;
  logic                       issue;
  logic                       ram_we;
  logic                       status_load;
  logic [cpd_pkg::WORD_W-1:0] ram_rdata;

  assign accept     = rx.valid && rx.ready;
  assign is_start   = (rx.rx_byte == start_marker);
  assign is_end     = (rx.rx_byte == end_marker);
  assign crc_ok     = (received_crc == running_crc);
  assign count_ok   = (rx.rx_byte <= MAX_BYTE);
  assign pos_inc    = word_position + CW'(1);
  assign rd_ptr_inc = rd_ptr + CW'(1);
  assign all_issued = (rd_ptr == word_count);
  assign move       = pend && (!out_valid || result.ready);
  assign issue      = (phase == cpd_pkg::PH_EMIT) && !all_issued && (!pend || move);

  // next state
  always_comb begin
    phase_next = phase;
    unique case (phase)
      cpd_pkg::PH_WAIT_START: begin
        if (accept && is_start) phase_next = cpd_pkg::PH_COUNT;
      end
      cpd_pkg::PH_COUNT: begin
        if (accept) begin
          if (!count_ok) phase_next = cpd_pkg::PH_WAIT_START;
          else if (rx.rx_byte == 8'd0) phase_next = cpd_pkg::PH_CRC_LO;
          else phase_next = cpd_pkg::PH_DATA;
        end
      end
      cpd_pkg::PH_DATA: begin
        if (accept && high_byte_next && (pos_inc >= word_count)) begin
          phase_next = cpd_pkg::PH_CRC_LO;
        end
      end
      cpd_pkg::PH_CRC_LO: begin
        if (accept) phase_next = cpd_pkg::PH_CRC_HI;
      end
      cpd_pkg::PH_CRC_HI: begin
        if (accept) phase_next = cpd_pkg::PH_WAIT_END;
      end
      cpd_pkg::PH_WAIT_END: begin
        if (accept) begin
          if (is_end && crc_ok && (word_count != '0)) phase_next = cpd_pkg::PH_EMIT;
          else phase_next = cpd_pkg::PH_WAIT_START;
        end
      end
      cpd_pkg::PH_EMIT: begin
        if (all_issued && (!pend || move)) phase_next = cpd_pkg::PH_WAIT_START;
      end
      default: phase_next = cpd_pkg::PH_WAIT_START;
    endcase
  end

  // phase outputs
  always_comb begin
    rx.ready    = 1'b1;
    ram_we      = 1'b0;
    status_load = 1'b0;
    unique case (phase)
      cpd_pkg::PH_DATA: begin
        ram_we = accept && high_byte_next;
      end
      cpd_pkg::PH_WAIT_END: begin
        rx.ready    = !out_valid || result.ready;
        status_load = accept && is_end && (!crc_ok || (word_count == '0));
      end
      cpd_pkg::PH_EMIT: begin
        rx.ready = 1'b0;
      end
      default: begin
        rx.ready = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cpd_pkg::PH_WAIT_START;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= cpd_pkg::START_MARKER_RESET;
      end_marker   <= cpd_pkg::END_MARKER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == cpd_pkg::REG_START_MARKER) start_marker <= cfg_data;
      if (cfg_index == cpd_pkg::REG_END_MARKER)   end_marker   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count     <= '0;
      word_position  <= '0;
      high_byte_next <= 1'b0;
      running_crc    <= cpd_pkg::CRC_INIT;
      received_crc   <= '0;
    end else if (accept) begin
      unique case (phase)
        cpd_pkg::PH_WAIT_START: begin
          if (is_start) running_crc <= crc_byte(cpd_pkg::CRC_INIT, rx.rx_byte);
        end
        cpd_pkg::PH_COUNT: begin
          if (count_ok) begin
            word_count     <= CW'(rx.rx_byte);
            word_position  <= '0;
            high_byte_next <= 1'b0;
            running_crc    <= crc_byte(running_crc, rx.rx_byte);
          end
        end
        cpd_pkg::PH_DATA: begin
          running_crc    <= crc_byte(running_crc, rx.rx_byte);
          high_byte_next <= !high_byte_next;
          if (high_byte_next) word_position <= pos_inc;
        end
        cpd_pkg::PH_CRC_LO: begin
          received_crc <= {8'h00, rx.rx_byte};
        end
        cpd_pkg::PH_CRC_HI: begin
          received_crc <= {rx.rx_byte, received_crc[7:0]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (phase == cpd_pkg::PH_DATA) && !high_byte_next) begin
      low_byte <= rx.rx_byte;
    end
  end

  // Writes happen only in the data phase and reads only in readout, so the
  // store never sees both on one entry at once.
  cpd_ram #(
    .WIDTH (cpd_pkg::WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_position[AW-1:0]),
    .wdata ({rx.rx_byte, low_byte}),
    .re    (issue),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else begin
      if (phase != cpd_pkg::PH_EMIT) rd_ptr <= '0;
      else if (issue) rd_ptr <= rd_ptr_inc;
      if (issue) pend <= 1'b1;
      else if (move) pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx  <= rd_ptr;
      pend_last <= (rd_ptr_inc == word_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status_load || move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status_load) begin
      out_status <= crc_ok ? cpd_pkg::ST_EMPTY : cpd_pkg::ST_CRC_ERR;
      out_idx    <= '0;
      out_value  <= '0;
      out_last   <= 1'b1;
    end else if (move) begin
      out_status <= cpd_pkg::ST_WORD;
      out_idx    <= cpd_pkg::INDEX_W'(pend_idx);
      out_value  <= ram_rdata;
      out_last   <= pend_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.frame_status  = out_status;
  assign result.word_index    = out_idx;
  assign result.word_value    = out_value;
  assign result.last_of_frame = out_last;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && issue))
    else $error("store write and readout in the same cycle");

  a_pend_in_emit: assert property (@(posedge clk) disable iff (rst)
    pend |-> (phase == cpd_pkg::PH_EMIT))
    else $error("read data pending outside readout");

  a_rd_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= word_count)
    else $error("readout pointer past word count");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    word_position <= word_count)
    else $error("write position past word count");

  a_status_shown: assert property (@(posedge clk) disable iff (rst)
    status_load |=> (result.valid && result.last_of_frame))
    else $error("status item not presented after END byte");

endmodule

### test/crc16_packet_deframer_top_tb.sv
// Self-checking testbench for crc16_packet_deframer_top: random and directed byte frames,
// per-item idle gaps on both channels, marker reprogramming and a long output stall.
// Depends on cpd_pkg, cpd_in_if, cpd_out_if and the deframer RTL.
`timescale 1ns / 1ps

module crc16_packet_deframer_top_tb;
  import cpd_pkg::*;

  localparam int MAX_WORDS    = DEFAULT_MAX_WORDS;
  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE       = 40;
  localparam int LONG_STALL   = 400;
  localparam int REPORT_MAX   = 10;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_OVERSIZE} frame_kind_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   index;
    logic [WORD_W-1:0]    value;
    logic                 last_mark;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  logic send_valid = 1'b0;
  logic [BYTE_W-1:0] send_byte = '0;
  logic recv_ready = 1'b0;

  cpd_in_if  in_ch ();
  cpd_out_if out_ch ();

  assign in_ch.valid   = send_valid;
  assign in_ch.rx_byte = send_byte;
  assign out_ch.ready  = recv_ready;

  crc16_packet_deframer_top #(.MAX_WORDS(MAX_WORDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (in_ch),
    .result    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // pending bytes, expected results, marker mirror
  logic [BYTE_W-1:0] byte_queue[$];
  logic [BYTE_W-1:0] frame_payload[$];
  frame_result_t     expected_results[$];
  logic [BYTE_W-1:0] start_mirror = START_MARKER_RESET;
  logic [BYTE_W-1:0] end_mirror   = END_MARKER_RESET;

  // deframer shadow state
  phase_t            sh_phase;
  logic [5:0]        sh_count;
  logic [5:0]        sh_pos;
  logic              sh_high_next;
  logic [WORD_W-1:0] sh_crc;
  logic [WORD_W-1:0] sh_rx_crc;
  logic [WORD_W-1:0] sh_store[MAX_WORDS];

  int bytes_queued = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int word_items = 0;
  int empty_items = 0;
  int crc_err_items = 0;
  int mismatches = 0;
  int settings_run = 1;
  int quiet_cycles = 0;

  logic send_idle_en = 1'b0;
  logic recv_idle_en = 1'b0;
  logic stall_req = 1'b0;
  logic stall_ack;
  int   send_gap;
  int   recv_gap;
  int   stall_cnt;

  function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    case (sh_phase)
      PH_WAIT_START: begin
        if (b == start_mirror) begin
          sh_crc = crc_step(CRC_INIT, b);
          sh_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (b <= MAX_WORDS) begin
          sh_count = 6'(b);
          sh_pos = '0;
          sh_high_next = 1'b0;
          sh_crc = crc_step(sh_crc, b);
          sh_phase = (b == 0) ? PH_CRC_LO : PH_DATA;
        end else begin
          sh_phase = PH_WAIT_START;
        end
      end
      PH_DATA: begin
        sh_crc = crc_step(sh_crc, b);
        if (sh_pos < MAX_WORDS) begin
          if (!sh_high_next) begin
            sh_store[sh_pos] = {8'h00, b};
            sh_high_next = 1'b1;
          end else begin
            sh_store[sh_pos][15:8] = b;
            sh_high_next = 1'b0;
            sh_pos = sh_pos + 6'd1;
            if (sh_pos >= sh_count) sh_phase = PH_CRC_LO;
          end
        end else begin
          sh_phase = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        sh_rx_crc = {8'h00, b};
        sh_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        sh_rx_crc[15:8] = b;
        sh_phase = PH_WAIT_END;
      end
      PH_WAIT_END: begin
        if (b == end_mirror) begin
          if (sh_rx_crc != sh_crc) begin
            r = '{ST_CRC_ERR, '0, '0, 1'b1};
            expected_results.push_back(r);
          end else if (sh_count == 0) begin
            r = '{ST_EMPTY, '0, '0, 1'b1};
            expected_results.push_back(r);
          end else begin
            for (int i = 0; i < sh_count; i++) begin
              r = '{ST_WORD, INDEX_W'(i), sh_store[i], (i + 1 == sh_count)};
              expected_results.push_back(r);
            end
          end
        end
        sh_phase = PH_WAIT_START;
      end
      default: sh_phase = PH_WAIT_START;
    endcase
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      send_gap <= 0;
      sh_phase = PH_WAIT_START;
      sh_count = '0;
      sh_pos = '0;
      sh_high_next = 1'b0;
      sh_crc = CRC_INIT;
      sh_rx_crc = '0;
    end else begin
      if (send_valid && in_ch.ready) begin
        predict_byte(send_byte);
        bytes_sent++;
      end
      if (!send_valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (byte_queue.size() != 0) begin
          send_valid <= 1'b1;
          send_byte <= byte_queue.pop_front();
          send_gap <= send_idle_en ? $urandom_range(0, 3) : 0;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    int g;
    if (rst) begin
      recv_ready <= 1'b0;
      recv_gap <= 0;
      stall_cnt <= 0;
      stall_ack <= 1'b0;
    end else begin
      if (out_ch.valid && recv_ready) begin
        results_seen++;
        case (out_ch.frame_status)
          ST_WORD:    word_items++;
          ST_EMPTY:   empty_items++;
          ST_CRC_ERR: crc_err_items++;
          default: ;
        endcase
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result status=%0d index=%0d value=%04h last=%0b",
                     $realtime, out_ch.frame_status, out_ch.word_index,
                     out_ch.word_value, out_ch.last_of_frame);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.frame_status !== want.status || out_ch.word_index !== want.index ||
              out_ch.word_value !== want.value ||
              out_ch.last_of_frame !== want.last_mark) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: result mismatch: expected status=%0d index=%0d value=%04h last=%0b",
                       $realtime, want.status, want.index, want.value, want.last_mark);
              $display("  got status=%0d index=%0d value=%04h last=%0b",
                       out_ch.frame_status, out_ch.word_index, out_ch.word_value,
                       out_ch.last_of_frame);
            end
          end
        end
      end
      if (stall_req != stall_ack) begin
        stall_ack <= stall_req;
        stall_cnt <= LONG_STALL;
        recv_ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt <= stall_cnt - 1;
        recv_ready <= (stall_cnt == 1);
      end else if (out_ch.valid && recv_ready) begin
        g = recv_idle_en ? $urandom_range(0, 3) : 0;
        recv_gap <= g;
        recv_ready <= (g == 0);
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        recv_ready <= (recv_gap == 1);
      end else begin
        recv_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (send_valid && in_ch.ready) || (out_ch.valid && recv_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  task automatic fill_payload(input int words);
    int r;
    frame_payload.delete();
    for (int i = 0; i < 2 * words; i++) begin
      r = $urandom_range(0, 7);
      frame_payload.push_back(r == 0 ? start_mirror : r == 1 ? end_mirror : 8'($urandom));
    end
  endtask

  task automatic queue_frame(input frame_kind_t kind);
    logic [WORD_W-1:0] crc;
    logic [WORD_W-1:0] sent_crc;
    logic [BYTE_W-1:0] count_byte;
    push_byte(start_mirror);
    crc = crc_step(CRC_INIT, start_mirror);
    if (kind == FR_OVERSIZE) begin
      push_byte(8'($urandom_range(MAX_WORDS + 1, 255)));
    end else begin
      count_byte = 8'(frame_payload.size() / 2);
      push_byte(count_byte);
      crc = crc_step(crc, count_byte);
      foreach (frame_payload[i]) begin
        push_byte(frame_payload[i]);
        crc = crc_step(crc, frame_payload[i]);
      end
      sent_crc = crc;
      if (kind == FR_BAD_CRC) begin
        // marker values in the CRC positions half the time
        sent_crc = $urandom_range(0, 1) ? {start_mirror, end_mirror}
                                        : crc ^ 16'($urandom_range(1, 16'hFFFF));
        if (sent_crc == crc) sent_crc = crc ^ 16'h0001;
      end
      push_byte(sent_crc[7:0]);
      push_byte(sent_crc[15:8]);
      push_byte(kind == FR_BAD_END ? end_mirror ^ 8'($urandom_range(1, 255)) : end_mirror);
    end
  endtask

  task automatic queue_traffic(input int n_bytes);
    int stop_at;
    int r;
    int words;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      r = $urandom_range(0, 99);
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      fill_payload(words);
      if (r < 70) queue_frame(FR_GOOD);
      else if (r < 80) queue_frame(FR_BAD_CRC);
      else if (r < 88) queue_frame(FR_BAD_END);
      else if (r < 94) queue_frame(FR_OVERSIZE);
      else repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || send_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_MARKER) start_mirror = val;
    else end_mirror = val;
  endtask

  task automatic set_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
    wait_drained();
    write_reg(REG_START_MARKER, s);
    write_reg(REG_END_MARKER, e);
    settings_run++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle bytes, empty frame, markers in data, crc error, bad close, oversize
    push_byte(8'h00);
    push_byte(8'hFF);
    frame_payload.delete();
    queue_frame(FR_GOOD);
    frame_payload = '{8'hAA, 8'h55, 8'hFF, 8'h00};
    queue_frame(FR_GOOD);
    frame_payload.delete();
    queue_frame(FR_BAD_CRC);
    queue_frame(FR_BAD_END);
    push_byte(start_mirror);
    push_byte(8'(MAX_WORDS + 1));
    wait_drained();

    send_idle_en <= 1'b1;
    recv_idle_en <= 1'b1;
    queue_traffic(8);

    set_markers(8'h00, 8'hFF);
    send_idle_en <= 1'b0;
    recv_idle_en <= 1'b0;
    queue_traffic(8);

    set_markers(8'hFF, 8'h00);
    send_idle_en <= 1'b1;
    queue_traffic(8);

    // equal markers, small enough to show up as counts too
    set_markers(8'h02, 8'h02);
    send_idle_en <= 1'b0;
    recv_idle_en <= 1'b1;
    queue_traffic(8);

    set_markers(8'($urandom), 8'($urandom));
    send_idle_en <= 1'b1;
    // long output stall against a full-size frame and more traffic behind it
    @(posedge clk);
    stall_req <= ~stall_req;
    fill_payload(MAX_WORDS);
    queue_frame(FR_GOOD);
    queue_traffic(8);
    wait_drained();

    $display("%0d bytes sent over %0d marker settings, %0d result items checked",
             bytes_sent, settings_run, results_seen);
    $display("  %0d words, %0d empty-frame and %0d crc-error statuses",
             word_items, empty_items, crc_err_items);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
